### rtl/tlwb_pkg.sv
// ----------------------------------------------------------------------------
// tlwb_pkg
// Shared widths, register indexes and types of the two-level cache unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tlwb_pkg;

  localparam int ADDR_W     = 20;
  localparam int DATA_W     = 32;
  localparam int COST_W     = 16;
  localparam int TIME_W     = 32;
  localparam int WORD_BYTES = 4;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_L1_READ  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_WRITE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_READ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_WRITE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_READ  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_WRITE = 3'd5;

  typedef struct packed {
    logic [COST_W-1:0] l1_read;
    logic [COST_W-1:0] l1_write;
    logic [COST_W-1:0] l2_read;
    logic [COST_W-1:0] l2_write;
    logic [COST_W-1:0] mem_read;
    logic [COST_W-1:0] mem_write;
  } costs_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [TIME_W-1:0] elapsed_time;
    logic              addr_error;
  } res_t;

endpackage

`default_nettype wire

### rtl/tlwb_if.sv
// ----------------------------------------------------------------------------
// tlwb_req_if / tlwb_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlwb_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [19:0] address;
  logic [31:0] write_data;
  modport source(output valid, req_type, address, write_data, input ready);
  modport sink(input valid, req_type, address, write_data, output ready);
endinterface

interface tlwb_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [31:0] elapsed_time;
  logic        addr_error;
  modport source(output valid, read_data, elapsed_time, addr_error, input ready);
  modport sink(input valid, read_data, elapsed_time, addr_error, output ready);
endinterface

`default_nettype wire

### rtl/two_level_write_back_cache_unit.sv
// ----------------------------------------------------------------------------
// two_level_write_back_cache_unit
// Word read/write through direct-mapped write-back L1 and L2 caches in
// front of a backing memory, with an access time counter.
// ----------------------------------------------------------------------------
// Requests arrive on in_req and one result item per request leaves on
// out_rsp, both valid/ready. Cost registers are written on the cfg_ port;
// the user must do so only while the unit is idle, as the unit does not
// enforce it. One request is worked on at a time; the next is taken once
// the result has moved to the output register, even while the receiver
// still stalls it. An L1 hit passes L1CHK, WORD and DONE on a write and
// L1CHK, WORD, RDW and DONE on a read. A whole-block move between levels
// goes word by word through the registered read port of the memory being
// copied; an L2 lookup adds L2RD and L2CHK. An address past the backing
// memory goes straight to DONE with an error item. After reset the backing
// memory and both tag arrays are swept to zero, one word per cycle, with
// in_req.ready low during the sweep. A stalled output holds its item.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_write_back_cache_unit #(
  parameter int BLOCK_BYTES = 64,
  parameter int L1_BYTES    = 16384,
  parameter int L2_BYTES    = 32768,
  parameter int MEM_BYTES   = 1048576
) (
  input  wire                             clk,
  input  wire                             rst_n,
  tlwb_req_if.sink                        in_req,
  tlwb_rsp_if.source                      out_rsp,
  input  wire                             cfg_we,
  input  wire [tlwb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [tlwb_pkg::COST_W-1:0]      cfg_wdata
);
  import tlwb_pkg::*;

  costs_t costs;
  res_t   res, out_res_r;
  logic   res_valid, res_ready, out_valid_r;

  tlwb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .costs     (costs)
  );

  tlwb_ctrl #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .L1_BYTES    (L1_BYTES),
    .L2_BYTES    (L2_BYTES),
    .MEM_BYTES   (MEM_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .costs     (costs),
    .req       (in_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res_r <= res;
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.read_data    = out_res_r.read_data;
  assign out_rsp.elapsed_time = out_res_r.elapsed_time;
  assign out_rsp.addr_error   = out_res_r.addr_error;

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid)
    else $error("result lost while output stage was full");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("second item taken while one is in work");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_rsp.valid)
    else $error("result not moved to output register");

  a_err_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.addr_error |-> out_rsp.read_data == '0)
    else $error("error item carries read data");

endmodule

`default_nettype wire

### rtl/tlwb_cfg.sv
// ----------------------------------------------------------------------------
// tlwb_cfg
// Access cost registers, written through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module tlwb_cfg (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [tlwb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [tlwb_pkg::COST_W-1:0]       cfg_wdata,
  output tlwb_pkg::costs_t                 costs
);
  import tlwb_pkg::*;

  costs_t costs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      costs_r.l1_read   <= 16'd1;
      costs_r.l1_write  <= 16'd1;
      costs_r.l2_read   <= 16'd10;
      costs_r.l2_write  <= 16'd10;
      costs_r.mem_read  <= 16'd100;
      costs_r.mem_write <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_L1_READ:   costs_r.l1_read   <= cfg_wdata;
        CFG_L1_WRITE:  costs_r.l1_write  <= cfg_wdata;
        CFG_L2_READ:   costs_r.l2_read   <= cfg_wdata;
        CFG_L2_WRITE:  costs_r.l2_write  <= cfg_wdata;
        CFG_MEM_READ:  costs_r.mem_read  <= cfg_wdata;
        CFG_MEM_WRITE: costs_r.mem_write <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign costs = costs_r;

endmodule

`default_nettype wire

### rtl/tlwb_ctrl.sv
// ----------------------------------------------------------------------------
// tlwb_ctrl
// Sequencer and memories: L1 and L2 tag and data arrays and backing store.
// ----------------------------------------------------------------------------
`default_nettype none

module tlwb_ctrl #(
  parameter int BLOCK_BYTES = 64,
  parameter int L1_BYTES    = 16384,
  parameter int L2_BYTES    = 32768,
  parameter int MEM_BYTES   = 1048576
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire tlwb_pkg::costs_t costs,
  tlwb_req_if.sink           req,
  output logic               res_valid,
  input  wire                res_ready,
  output tlwb_pkg::res_t     res
);
  import tlwb_pkg::*;

  localparam int WPB       = BLOCK_BYTES / WORD_BYTES;
  localparam int OFF_W     = $clog2(WPB);
  localparam int BLK_W     = $clog2(BLOCK_BYTES);
  localparam int L1_LINES  = L1_BYTES / BLOCK_BYTES;
  localparam int L2_LINES  = L2_BYTES / BLOCK_BYTES;
  localparam int MEM_WORDS = MEM_BYTES / WORD_BYTES;
  localparam int L1_IW     = $clog2(L1_LINES);
  localparam int L2_IW     = $clog2(L2_LINES);
  localparam int L1_TW     = ADDR_W - BLK_W - L1_IW;
  localparam int L2_TW     = ADDR_W - BLK_W - L2_IW;
  localparam int L1_DW     = L1_IW + OFF_W;
  localparam int L2_DW     = L2_IW + OFF_W;
  localparam int MW_W      = $clog2(MEM_WORDS);
  localparam int CMP_W     = ((ADDR_W > MW_W + 2) ? ADDR_W : MW_W + 2) + 1;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_L1CHK = 4'd2;
  localparam logic [3:0] ST_L2RD  = 4'd3;
  localparam logic [3:0] ST_L2CHK = 4'd4;
  localparam logic [3:0] ST_COPY  = 4'd5;
  localparam logic [3:0] ST_WORD  = 4'd6;
  localparam logic [3:0] ST_RDW   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  localparam logic [1:0] K_L2_TO_MEM = 2'd0;
  localparam logic [1:0] K_MEM_TO_L2 = 2'd1;
  localparam logic [1:0] K_L1_TO_L2  = 2'd2;
  localparam logic [1:0] K_L2_TO_L1  = 2'd3;

  // Memories.
  logic [L1_TW+1:0]  l1m_mem [L1_LINES];
  logic [L2_TW+1:0]  l2m_mem [L2_LINES];
  logic [DATA_W-1:0] l1d_mem [L1_LINES*WPB];
  logic [DATA_W-1:0] l2d_mem [L2_LINES*WPB];
  logic [DATA_W-1:0] bm_mem  [MEM_WORDS];

  logic [L1_TW+1:0]  l1m_q, l1m_wd;
  logic [L2_TW+1:0]  l2m_q, l2m_wd;
  logic [DATA_W-1:0] l1d_q, l1d_wd, l2d_q, l2d_wd, bm_q, bm_wd;
  logic [L1_IW-1:0]  l1m_ra, l1m_wa;
  logic [L2_IW-1:0]  l2m_ra, l2m_wa;
  logic [L1_DW-1:0]  l1d_ra, l1d_wa;
  logic [L2_DW-1:0]  l2d_ra, l2d_wa;
  logic [MW_W-1:0]   bm_ra, bm_wa;
  logic              l1m_we, l2m_we, l1d_we, l2d_we, bm_we;

  always_ff @(posedge clk) begin
    if (l1m_we) l1m_mem[l1m_wa] <= l1m_wd;
    l1m_q <= l1m_mem[l1m_ra];
  end
  always_ff @(posedge clk) begin
    if (l2m_we) l2m_mem[l2m_wa] <= l2m_wd;
    l2m_q <= l2m_mem[l2m_ra];
  end
  always_ff @(posedge clk) begin
    if (l1d_we) l1d_mem[l1d_wa] <= l1d_wd;
    l1d_q <= l1d_mem[l1d_ra];
  end
  always_ff @(posedge clk) begin
    if (l2d_we) l2d_mem[l2d_wa] <= l2d_wd;
    l2d_q <= l2d_mem[l2d_ra];
  end
  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_wa] <= bm_wd;
    bm_q <= bm_mem[bm_ra];
  end

  // Control registers.
  logic [3:0]        state_r, state_nxt;
  logic [MW_W-1:0]   clr_r, clr_nxt;
  logic              wr_r, wr_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [DATA_W-1:0] wdata_r, wdata_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [ADDR_W-1:0] op_blk_r, op_blk_nxt;
  logic              fill_r, fill_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [OFF_W:0]    cnt_r, cnt_nxt;
  logic [L2_TW-1:0]  l2vtag_r, l2vtag_nxt;
  logic [DATA_W-1:0] rdata_r, rdata_nxt;
  logic              err_r, err_nxt;
  logic [COST_W-1:0] add_cost;

  logic [L1_IW-1:0]  req_l1i, op_l1i;
  logic [L2_IW-1:0]  op_l2i;
  logic [L1_TW-1:0]  req_l1t;
  logic [L2_TW-1:0]  op_l2t;
  logic [OFF_W-1:0]  req_off, cur_off, prev_off;
  logic [ADDR_W-1:0] vic_blk, in_blk;
  logic              addr_bad, l1_hit, l2_hit, copy_end;

  assign req_l1i  = addr_r[BLK_W +: L1_IW];
  assign req_l1t  = addr_r[ADDR_W-1 -: L1_TW];
  assign req_off  = addr_r[2 +: OFF_W];
  assign op_l1i   = op_blk_r[BLK_W +: L1_IW];
  assign op_l2i   = op_blk_r[BLK_W +: L2_IW];
  assign op_l2t   = op_blk_r[ADDR_W-1 -: L2_TW];
  assign cur_off  = cnt_r[OFF_W-1:0];
  assign prev_off = OFF_W'(cnt_r - 1'b1);
  assign vic_blk  = {l2vtag_r, op_l2i, {BLK_W{1'b0}}};
  assign in_blk   = {addr_r[ADDR_W-1:BLK_W], {BLK_W{1'b0}}};
  assign addr_bad = CMP_W'(req.address) >= CMP_W'(MEM_BYTES);
  assign l1_hit   = l1m_q[L1_TW+1] && (l1m_q[L1_TW-1:0] == req_l1t);
  assign l2_hit   = l2m_q[L2_TW+1] && (l2m_q[L2_TW-1:0] == op_l2t);
  assign copy_end = cnt_r == (OFF_W+1)'(WPB);

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    wr_nxt     = wr_r;
    addr_nxt   = addr_r;
    wdata_nxt  = wdata_r;
    op_blk_nxt = op_blk_r;
    fill_nxt   = fill_r;
    kind_nxt   = kind_r;
    cnt_nxt    = cnt_r;
    l2vtag_nxt = l2vtag_r;
    rdata_nxt  = rdata_r;
    err_nxt    = err_r;
    add_cost   = '0;

    l1m_we = 1'b0; l1m_wa = req_l1i; l1m_wd = {1'b1, 1'b0, req_l1t};
    l1m_ra = req.address[BLK_W +: L1_IW];
    l2m_we = 1'b0; l2m_wa = op_l2i; l2m_wd = {1'b1, 1'b0, op_l2t};
    l2m_ra = op_l2i;
    l1d_we = 1'b0; l1d_wa = {op_l1i, prev_off}; l1d_wd = l2d_q;
    l1d_ra = {op_l1i, cur_off};
    l2d_we = 1'b0; l2d_wa = {op_l2i, prev_off}; l2d_wd = bm_q;
    l2d_ra = {op_l2i, cur_off};
    bm_we  = 1'b0; bm_wd = l2d_q;
    bm_wa  = MW_W'({vic_blk[ADDR_W-1:BLK_W], prev_off});
    bm_ra  = MW_W'({op_blk_r[ADDR_W-1:BLK_W], cur_off});

    unique case (state_r)
      ST_CLEAR: begin
        bm_we  = 1'b1;
        bm_wa  = clr_r;
        bm_wd  = '0;
        l1m_we = clr_r < MW_W'(L1_LINES);
        l1m_wa = clr_r[L1_IW-1:0];
        l1m_wd = '0;
        l2m_we = clr_r < MW_W'(L2_LINES);
        l2m_wa = clr_r[L2_IW-1:0];
        l2m_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == MW_W'(MEM_WORDS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (req.valid) begin
          wr_nxt    = req.req_type;
          addr_nxt  = req.address;
          wdata_nxt = req.write_data;
          rdata_nxt = '0;
          err_nxt   = addr_bad;
          state_nxt = addr_bad ? ST_DONE : ST_L1CHK;
        end
      end
      ST_L1CHK: begin
        if (l1_hit) begin
          state_nxt = ST_WORD;
        end else begin
          if (l1m_q[L1_TW+1] && l1m_q[L1_TW]) begin
            op_blk_nxt = {l1m_q[L1_TW-1:0], req_l1i, {BLK_W{1'b0}}};
            fill_nxt   = 1'b0;
          end else begin
            op_blk_nxt = in_blk;
            fill_nxt   = 1'b1;
          end
          state_nxt = ST_L2RD;
        end
      end
      ST_L2RD: begin
        state_nxt = ST_L2CHK;
      end
      ST_L2CHK: begin
        cnt_nxt   = '0;
        state_nxt = ST_COPY;
        if (l2_hit) begin
          kind_nxt = fill_r ? K_L2_TO_L1 : K_L1_TO_L2;
          add_cost = fill_r ? costs.l2_read : costs.l2_write;
        end else if (l2m_q[L2_TW+1] && l2m_q[L2_TW]) begin
          l2vtag_nxt = l2m_q[L2_TW-1:0];
          kind_nxt   = K_L2_TO_MEM;
          add_cost   = costs.mem_write;
        end else begin
          kind_nxt = K_MEM_TO_L2;
          add_cost = costs.mem_read;
        end
      end
      ST_COPY: begin
        cnt_nxt = cnt_r + 1'b1;
        case (kind_r)
          K_L2_TO_MEM: bm_we = cnt_r != '0;
          K_MEM_TO_L2: l2d_we = cnt_r != '0;
          K_L1_TO_L2: begin
            l2d_we = cnt_r != '0;
            l2d_wd = l1d_q;
          end
          default: l1d_we = cnt_r != '0;
        endcase
        if (copy_end) begin
          cnt_nxt = '0;
          case (kind_r)
            K_L2_TO_MEM: begin
              kind_nxt = K_MEM_TO_L2;
              add_cost = costs.mem_read;
            end
            K_MEM_TO_L2: begin
              l2m_we   = 1'b1;
              kind_nxt = fill_r ? K_L2_TO_L1 : K_L1_TO_L2;
              add_cost = fill_r ? costs.l2_read : costs.l2_write;
            end
            K_L1_TO_L2: begin
              l2m_we     = 1'b1;
              l2m_wd     = {1'b1, 1'b1, op_l2t};
              fill_nxt   = 1'b1;
              op_blk_nxt = in_blk;
              state_nxt  = ST_L2RD;
            end
            default: begin
              l1m_we    = 1'b1;
              state_nxt = ST_WORD;
            end
          endcase
        end
      end
      ST_WORD: begin
        l1d_ra = {req_l1i, req_off};
        if (wr_r) begin
          l1d_we    = 1'b1;
          l1d_wa    = {req_l1i, req_off};
          l1d_wd    = wdata_r;
          l1m_we    = 1'b1;
          l1m_wd    = {1'b1, 1'b1, req_l1t};
          add_cost  = costs.l1_write;
          state_nxt = ST_DONE;
        end else begin
          add_cost  = costs.l1_read;
          state_nxt = ST_RDW;
        end
      end
      ST_RDW: begin
        rdata_nxt = l1d_q;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    time_nxt = time_r + TIME_W'(add_cost);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      time_r  <= '0;
      cnt_r   <= '0;
      kind_r  <= K_L2_TO_MEM;
      fill_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      time_r  <= time_nxt;
      cnt_r   <= cnt_nxt;
      kind_r  <= kind_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_r     <= wr_nxt;
    addr_r   <= addr_nxt;
    wdata_r  <= wdata_nxt;
    op_blk_r <= op_blk_nxt;
    l2vtag_r <= l2vtag_nxt;
    rdata_r  <= rdata_nxt;
    err_r    <= err_nxt;
  end

  assign req.ready        = state_r == ST_IDLE;
  assign res_valid        = state_r == ST_DONE;
  assign res.read_data    = rdata_r;
  assign res.elapsed_time = time_r;
  assign res.addr_error   = err_r;

endmodule

`default_nettype wire
